// ===== src/bsq_pkg.sv =====
// Shared types, constants and the wave table builder of the step sequencer.
`timescale 1ns / 1ps
`default_nettype none
package bsq_pkg;

	localparam int CHANNELS  = 6;
	localparam int PAT_ROWS  = 128;
	localparam int WAVE_SIZE = 512;
	localparam int WAVE_W    = 9;

	localparam logic [31:0] GAIN_ONE    = 32'h1000_0000;
	localparam longint      Q30_ONE     = 64'd1073741824;
	localparam longint      HALF_PI_Q30 = 64'd1686629713;

	// Configuration register indexes (word index taken from paddr[2]).
	localparam logic REG_PRESET_COUNT = 1'b0;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_GAIN   = 2'd1,
		OP_SELECT = 2'd2,
		OP_WRITE  = 2'd3
	} op_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		op_t                op;
		logic [2:0]         chan;
		logic [2:0]         preset;
		logic [3:0]         step;
		logic signed [15:0] value;
		logic [23:0]        len;
		logic [3:0]         bar;
		logic [WAVE_W-1:0]  phase;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_LOAD,
		ST_MUL,
		ST_MUL2,
		ST_OUT,
		ST_DIV,
		ST_DIVW
	} state_t;

	// Each entry holds the raised sine (0.15, bits 31:17) and raised cosine (bits 16:0).
	typedef logic [31:0] wave_tab_t [WAVE_SIZE];

	// Builds the wave table at elaboration: quadrant reduction and a Taylor series.
	function automatic wave_tab_t build_wave();
		wave_tab_t tab;
		longint    u, a, a2, t, ss, cc, sv, cv, vf, vq;
		longint    quad;
		int        i;
		for (i = 0; i < WAVE_SIZE; i++) begin
			u    = (longint'(i) <<< 32) / WAVE_SIZE;
			quad = (u >>> 30) & 3;
			a    = ((u & 64'h3FFF_FFFF) * HALF_PI_Q30) >>> 30;
			a2   = (a * a) >>> 30;
			t  = a;
			ss = a;
			t  = ((t * a2) >>> 30) / 6;   ss = ss - t;
			t  = ((t * a2) >>> 30) / 20;  ss = ss + t;
			t  = ((t * a2) >>> 30) / 42;  ss = ss - t;
			t  = ((t * a2) >>> 30) / 72;  ss = ss + t;
			t  = ((t * a2) >>> 30) / 110; ss = ss - t;
			t  = ((t * a2) >>> 30) / 156; ss = ss + t;
			t  = Q30_ONE;
			cc = Q30_ONE;
			t  = ((t * a2) >>> 30) / 2;   cc = cc - t;
			t  = ((t * a2) >>> 30) / 12;  cc = cc + t;
			t  = ((t * a2) >>> 30) / 30;  cc = cc - t;
			t  = ((t * a2) >>> 30) / 56;  cc = cc + t;
			t  = ((t * a2) >>> 30) / 90;  cc = cc - t;
			t  = ((t * a2) >>> 30) / 132; cc = cc + t;
			if (ss < 0) ss = 0;
			if (ss > Q30_ONE) ss = Q30_ONE;
			if (cc < 0) cc = 0;
			if (cc > Q30_ONE) cc = Q30_ONE;
			case (quad)
				0: begin sv = ss;  cv = cc;  end
				1: begin sv = cc;  cv = -ss; end
				2: begin sv = -ss; cv = -cc; end
				default: begin sv = -cc; cv = ss; end
			endcase
			vf = (Q30_ONE + cv + 32768) >>> 16;
			vq = ((Q30_ONE / 2) + (2 * sv) / 5 + 16384) >>> 15;
			tab[i] = {vq[14:0], vf[16:0]};
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

// ===== src/bar_step_cv_sequencer.sv =====
// Top level of the bar step control-voltage sequencer.
//
// Items arrive on the s_axis channel: tuser carries the kind (sample, gain or
// fade, preset select, pattern write) and tdata the other fields. A sample
// yields one result on m_axis; the other kinds yield none. preset_count is
// to be written over the APB port while the block is idle; the block itself
// does not enforce this. The front registers and classifies each transfer
// and drops ignored items; a four-entry queue separates it from the back,
// which runs one command at a time. A sample passes through the back in
// order: queue read, gain step and bar check, pattern read, two multiply
// stages and result; the next command is taken only once the result is in
// the output register. A fade with nonzero length runs the serial divider
// for 33 bits; selects and pattern writes are done as they leave the queue.
// Reset clears the bar, rotation, active preset, held levels and fades, and
// sets every gain to one; the pattern memory holds nothing until written.
// When the receiver stalls, the finished result waits in the output register
// while the back keeps taking commands until the next sample reaches the
// result step; the queue then fills and s_axis_tready falls.
`timescale 1ns / 1ps
`default_nettype none
module bar_step_cv_sequencer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// APB configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// Input stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// beat_time[19:0], channel[22:20], preset_index[25:23], step_index[29:26],
	// gain_target[45:30], fade_length[69:46], pattern_value[85:70], zero[87:86]
	input  wire logic [87:0]  s_axis_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	// Result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// cv_bass[19:0], cv_mid[39:20], cv_high[59:40], cv_echo[79:60],
	// cv_detune[99:80], freq_one[115:100], reso_one[135:116],
	// freq_two[151:136], reso_two[171:152], zero[175:172]
	output logic [175:0]      m_axis_tdata
);

	logic          [3:0] preset_count_q;
	logic                push;
	logic                full;
	logic                pop;
	logic                empty;
	bsq_pkg::cmd_t       push_cmd;
	bsq_pkg::cmd_t       head_cmd;

	// Register file: one register, word index in paddr[2].
	assign pready = 1'b1;
	assign prdata = (paddr[2] == bsq_pkg::REG_PRESET_COUNT) ? {28'h0, preset_count_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_count_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == bsq_pkg::REG_PRESET_COUNT)) begin
			preset_count_q <= pwdata[3:0];
		end
	end

	bsq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.preset_count  (preset_count_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.cmd           (push_cmd),
		.full          (full)
	);

	bsq_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (full),
		.pop    (pop),
		.dout   (head_cmd),
		.empty  (empty)
	);

	bsq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.preset_count  (preset_count_q),
		.fifo_empty    (empty),
		.fifo_head     (head_cmd),
		.fifo_pop      (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ===== src/bsq_front.sv =====
// Front end: accepts input transfers, classifies them and drops ignored items.
`timescale 1ns / 1ps
`default_nettype none
module bsq_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [3:0]         preset_count,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [87:0]        s_axis_tdata,
	input  wire logic [1:0]         s_axis_tuser,
	output logic                    push,
	output bsq_pkg::cmd_t           cmd,
	input  wire logic               full
);

	logic          valid_s1;
	bsq_pkg::cmd_t cmd_s1;
	bsq_pkg::cmd_t cmd_new;
	logic          keep;
	logic          accept;

	assign s_axis_tready = !valid_s1 || !full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = valid_s1 && !full;
	assign cmd           = cmd_s1;

	// Decode the fields; a sample gets its bar and wave phase here.
	always_comb begin
		cmd_new.op     = bsq_pkg::op_t'(s_axis_tuser);
		cmd_new.chan   = s_axis_tdata[22:20];
		cmd_new.preset = s_axis_tdata[25:23];
		cmd_new.step   = s_axis_tdata[29:26];
		cmd_new.len    = s_axis_tdata[69:46];
		cmd_new.value  = (cmd_new.op == bsq_pkg::OP_WRITE) ? s_axis_tdata[85:70]
			: s_axis_tdata[45:30];
		if (s_axis_tdata[19]) begin
			cmd_new.bar   = 4'd0;
			cmd_new.phase = '0;
		end else begin
			cmd_new.bar   = s_axis_tdata[18] ? 4'hF : s_axis_tdata[17:14];
			cmd_new.phase = s_axis_tdata[13:5];
		end
		case (cmd_new.op)
			bsq_pkg::OP_SAMPLE: keep = 1'b1;
			bsq_pkg::OP_GAIN:   keep = cmd_new.chan < 3'(bsq_pkg::CHANNELS);
			bsq_pkg::OP_SELECT: keep = {1'b0, cmd_new.preset} < preset_count;
			bsq_pkg::OP_WRITE:  keep = cmd_new.chan < 3'(bsq_pkg::CHANNELS);
			default:            keep = 1'b0;
		endcase
	end

	// Stage register toward the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule
`default_nettype wire

// ===== src/bsq_fifo.sv =====
// Four-entry command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module bsq_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bsq_pkg::cmd_t din,
	output logic               full,
	input  wire logic          pop,
	output bsq_pkg::cmd_t      dout,
	output logic               empty
);

	bsq_pkg::cmd_t entry_q [4];
	logic [1:0]    wr_ptr_q;
	logic [1:0]    rd_ptr_q;
	logic [2:0]    count_q;

	assign full  = count_q == 3'd4;
	assign empty = count_q == 3'd0;
	assign dout  = entry_q[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (push && !pop) begin
				count_q <= count_q + 3'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

// ===== src/bsq_div.sv =====
// Serial restoring divider for fade steps, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bsq_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] num,
	input  wire logic [23:0] den,
	output logic             done,
	output logic [32:0]      quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [32:0] quo_q;
	logic [24:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[32]};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	// Control: 33 steps after a start, then a one-cycle done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd32);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: shift the dividend out and the quotient in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? 24'(trial - {1'b0, den_q}) : trial[23:0];
			quo_q <= {quo_q[31:0], fits};
		end
	end

endmodule
`default_nettype wire

// ===== src/bsq_back.sv =====
// Back end: executes queued commands, holds sequencer state and the result register.
`timescale 1ns / 1ps
`default_nettype none
module bsq_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [3:0]    preset_count,
	input  wire logic          fifo_empty,
	input  wire bsq_pkg::cmd_t fifo_head,
	output logic               fifo_pop,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [175:0]       m_axis_tdata
);

	localparam int CH = bsq_pkg::CHANNELS;
	localparam bsq_pkg::wave_tab_t WaveRom = bsq_pkg::build_wave();

	bsq_pkg::state_t state_q, state_nxt;
	bsq_pkg::cmd_t   cmd_q;

	logic [3:0]         bar_now_q;
	logic [4:0]         rotate_q;
	logic [2:0]         active_q;
	logic               load_q;
	logic signed [15:0] held_q      [CH];
	logic signed [31:0] gain_acc_q  [CH];
	logic signed [31:0] gain_step_q [CH];
	logic [23:0]        fade_left_q [CH];

	logic [15:0]        pat_rd [CH];
	logic [6:0]         rd_row;
	logic [6:0]         wr_row;
	logic               wr_en;
	logic [31:0]        wave_q;

	logic signed [47:0] prod_cv_q [5];
	logic signed [33:0] prod_f_q;
	logic signed [31:0] prod_v_q;
	logic signed [63:0] prod_r_q;

	logic               out_free;
	logic               out_load;
	logic               div_start;
	logic               div_done;
	logic [32:0]        div_quo;
	logic               neg_q;
	logic signed [32:0] num;
	logic [32:0]        num_mag;
	logic signed [31:0] tgt;
	logic signed [31:0] step_new;
	logic               m_valid_q;
	logic [175:0]       tdata_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = tdata_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bsq_pkg::ST_IDLE: begin
				if (!fifo_empty) begin
					if (fifo_head.op == bsq_pkg::OP_SAMPLE) begin
						state_nxt = bsq_pkg::ST_GAIN;
					end else if (fifo_head.op == bsq_pkg::OP_GAIN) begin
						state_nxt = bsq_pkg::ST_DIV;
					end
				end
			end
			bsq_pkg::ST_GAIN: state_nxt = bsq_pkg::ST_LOAD;
			bsq_pkg::ST_LOAD: state_nxt = bsq_pkg::ST_MUL;
			bsq_pkg::ST_MUL:  state_nxt = bsq_pkg::ST_MUL2;
			bsq_pkg::ST_MUL2: state_nxt = bsq_pkg::ST_OUT;
			bsq_pkg::ST_OUT: begin
				if (out_free) state_nxt = bsq_pkg::ST_IDLE;
			end
			bsq_pkg::ST_DIV: begin
				state_nxt = (cmd_q.len == '0) ? bsq_pkg::ST_IDLE : bsq_pkg::ST_DIVW;
			end
			bsq_pkg::ST_DIVW: begin
				if (div_done) state_nxt = bsq_pkg::ST_IDLE;
			end
			default: state_nxt = bsq_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		fifo_pop  = (state_q == bsq_pkg::ST_IDLE) && !fifo_empty;
		wr_en     = fifo_pop && (fifo_head.op == bsq_pkg::OP_WRITE);
		div_start = (state_q == bsq_pkg::ST_DIV) && (cmd_q.len != '0);
		out_load  = (state_q == bsq_pkg::ST_OUT) && out_free;
	end

	// Pattern read row uses the new bar and the rotation; writes come from the queue head.
	assign rd_row = {active_q, 4'(cmd_q.bar - rotate_q[3:0])};
	assign wr_row = {fifo_head.preset, fifo_head.step};

	// One pattern memory lane per channel, all read at the same row.
	for (genvar k = 0; k < CH; k++) begin : g_lane
		logic [15:0] pat_mem [bsq_pkg::PAT_ROWS];
		always_ff @(posedge clk) begin
			if (wr_en && (fifo_head.chan == 3'(k))) begin
				pat_mem[wr_row] <= fifo_head.value;
			end
			pat_rd[k] <= pat_mem[rd_row];
		end
	end

	// Wave table read at the sample's phase.
	always_ff @(posedge clk) begin
		wave_q <= WaveRom[cmd_q.phase];
	end

	// Fade step numerator and its magnitude for the divider.
	always_comb begin
		tgt      = {cmd_q.value, 16'h0000};
		num      = 33'(tgt) - 33'(gain_acc_q[cmd_q.chan]);
		num_mag  = num[32] ? 33'(-num) : 33'(num);
		if (neg_q) begin
			step_new = (div_quo > 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
		end else begin
			step_new = (div_quo > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
		end
	end

	bsq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_mag),
		.den    (cmd_q.len),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bsq_pkg::ST_IDLE;
			bar_now_q <= '0;
			rotate_q  <= '0;
			active_q  <= '0;
			load_q    <= 1'b0;
			m_valid_q <= 1'b0;
			for (int k = 0; k < CH; k++) begin
				held_q[k]      <= '0;
				gain_acc_q[k]  <= bsq_pkg::GAIN_ONE;
				gain_step_q[k] <= '0;
				fade_left_q[k] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (fifo_pop && (fifo_head.op == bsq_pkg::OP_SELECT)) begin
				rotate_q <= {1'b0, bar_now_q} + 5'd1;
				active_q <= fifo_head.preset;
			end
			if (state_q == bsq_pkg::ST_GAIN) begin
				for (int k = 0; k < CH; k++) begin
					if (fade_left_q[k] != '0) begin
						logic signed [32:0] sum;
						sum = 33'(gain_acc_q[k]) + 33'(gain_step_q[k]);
						if (sum[32] != sum[31]) begin
							gain_acc_q[k] <= sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
						end else begin
							gain_acc_q[k] <= sum[31:0];
						end
						fade_left_q[k] <= fade_left_q[k] - 24'd1;
					end
				end
				load_q <= 1'b0;
				if (cmd_q.bar != bar_now_q) begin
					bar_now_q <= cmd_q.bar;
					load_q    <= {1'b0, active_q} < preset_count;
				end
			end
			if ((state_q == bsq_pkg::ST_LOAD) && load_q) begin
				for (int k = 0; k < CH; k++) begin
					held_q[k] <= pat_rd[k];
				end
			end
			if ((state_q == bsq_pkg::ST_DIV) && (cmd_q.len == '0)) begin
				gain_acc_q[cmd_q.chan]  <= tgt;
				gain_step_q[cmd_q.chan] <= '0;
				fade_left_q[cmd_q.chan] <= '0;
			end
			if (div_done) begin
				gain_step_q[cmd_q.chan] <= step_new;
				fade_left_q[cmd_q.chan] <= cmd_q.len;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Products and result assembly; every product already fits its field.
	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			cmd_q <= fifo_head;
		end
		if (div_start) begin
			neg_q <= num[32];
		end
		if (state_q == bsq_pkg::ST_MUL) begin
			for (int k = 0; k < 5; k++) begin
				prod_cv_q[k] <= held_q[k] * gain_acc_q[k];
			end
			prod_f_q <= held_q[5] * $signed({1'b0, wave_q[16:0]});
			prod_v_q <= held_q[5] * $signed({1'b0, wave_q[31:17]});
		end
		if (state_q == bsq_pkg::ST_MUL2) begin
			prod_r_q <= prod_v_q * gain_acc_q[5];
		end
		if (out_load) begin
			tdata_q <= {4'h0, prod_r_q[62:43], prod_f_q[30:15], prod_r_q[62:43],
				prod_f_q[30:15], prod_cv_q[4][47:28], prod_cv_q[3][47:28],
				prod_cv_q[2][47:28], prod_cv_q[1][47:28], prod_cv_q[0][47:28]};
		end
	end

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_axis_tready))
		else $error("result register overwritten");

	// The divider only finishes while a fade command waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == bsq_pkg::ST_DIVW))
		else $error("divider done outside of a fade command");

	// A new result only appears out of the output state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == bsq_pkg::ST_OUT))
		else $error("result shown without a sample");

	// The queue is only read from the idle state.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |=> (state_q == bsq_pkg::ST_IDLE) || (state_q == bsq_pkg::ST_GAIN)
			|| (state_q == bsq_pkg::ST_DIV))
		else $error("queue read while busy");

endmodule
`default_nettype wire
